// ===== rtl/core/btk_pkg.sv =====
package btk_pkg;

  localparam int ENC_W      = 1;
  localparam int MENU_W     = 2;
  localparam int RATE_W     = 6;
  localparam int VOL_W      = 7;
  localparam int INSP_W     = 2;
  localparam int EXP_W      = 3;
  localparam int IDX_W      = 3;
  localparam int AGE_W      = 8;
  localparam int STEPS_W    = 16;
  localparam int TRIM_W     = 10;
  localparam int MS_W       = 14;
  localparam int SRATE_W    = 24;
  localparam int DEN_W      = 9;
  localparam int NUM_W      = 20;
  localparam int PROD_W     = STEPS_W + VOL_W;
  localparam int DIV_DW     = PROD_W + 3;
  localparam int DIV_SW     = MS_W;
  localparam int DIV_CNT_W  = 5;
  localparam int MUL_CNT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MENU_W-1:0] MENU_RATE  = 2'd0;
  localparam logic [MENU_W-1:0] MENU_VOL   = 2'd1;
  localparam logic [MENU_W-1:0] MENU_RATIO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INSP_TRIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_TRIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd3;

  localparam logic [RATE_W-1:0]  RATE_MAX   = 6'd40;
  localparam logic [RATE_W-1:0]  RATE_MIN   = 6'd6;
  localparam logic [VOL_W-1:0]   VOL_MAX    = 7'd100;
  localparam logic [VOL_W-1:0]   VOL_MIN    = 7'd10;
  localparam logic [IDX_W-1:0]   RATIO_LAST = 3'd4;
  localparam logic [AGE_W-1:0]   AGE_MAX    = 8'd255;
  localparam logic [NUM_W-1:0]   MS_PER_MIN = 20'd60000;
  localparam logic [DIV_SW-1:0]  PCT_DIV    = 14'd100;
  localparam logic [SRATE_W-1:0] SRATE_MAX  = 24'hFFFFFF;

  localparam logic [STEPS_W-1:0] STEPS_RST     = 16'd440;
  localparam logic [TRIM_W-1:0]  INSP_TRIM_RST = 10'd30;
  localparam logic [TRIM_W-1:0]  EXP_TRIM_RST  = 10'd0;
  localparam logic [AGE_W-1:0]   HOLDOFF_RST   = 8'd120;

  typedef struct packed {
    logic [MENU_W-1:0] menu;
    logic [RATE_W-1:0] rate;
    logic [VOL_W-1:0]  volume;
    logic [INSP_W-1:0] insp_share;
    logic [EXP_W-1:0]  exp_share;
    logic              changed;
  } knob_t;

  function automatic logic [INSP_W-1:0] insp_of(input logic [IDX_W-1:0] idx);
    logic [INSP_W-1:0] r;
    r = (idx == '0) ? 2'd2 : 2'd1;
    return r;
  endfunction

  function automatic logic [EXP_W-1:0] exp_of(input logic [IDX_W-1:0] idx);
    logic [EXP_W-1:0] r;
    unique case (idx)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd4;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/btk_in_if.sv =====
interface btk_in_if;
  logic valid;
  logic ready;
  logic enc_a;
  logic enc_b;
  logic enc_push;

  modport source (output valid, enc_a, enc_b, enc_push, input ready);
  modport sink   (input valid, enc_a, enc_b, enc_push, output ready);
endinterface

// ===== rtl/core/btk_out_if.sv =====
interface btk_out_if;
  import btk_pkg::*;

  logic               valid;
  logic               ready;
  logic [MENU_W-1:0]  menu_pos;
  logic [RATE_W-1:0]  rate_out;
  logic [VOL_W-1:0]   volume_out;
  logic [INSP_W-1:0]  insp_part;
  logic [EXP_W-1:0]   exp_part;
  logic [STEPS_W-1:0] stroke_steps;
  logic [SRATE_W-1:0] step_rate;
  logic [MS_W-1:0]    insp_ms;
  logic [MS_W-1:0]    exp_ms;
  logic               settings_changed;

  modport source (output valid, menu_pos, rate_out, volume_out, insp_part, exp_part,
                  stroke_steps, step_rate, insp_ms, exp_ms, settings_changed,
                  input ready);
  modport sink   (input valid, menu_pos, rate_out, volume_out, insp_part, exp_part,
                  stroke_steps, step_rate, insp_ms, exp_ms, settings_changed,
                  output ready);
endinterface

// ===== rtl/core/btk_cfg_if.sv =====
interface btk_cfg_if;
  import btk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/btk_knob.sv =====
module btk_knob (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     enc_a,
  input  logic                     enc_b,
  input  logic                     enc_push,
  input  logic [btk_pkg::AGE_W-1:0] holdoff,
  output btk_pkg::knob_t           knob
);
  import btk_pkg::*;

  logic [MENU_W-1:0] menu_r, menu_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt, idx_clamp;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [VOL_W-1:0]  vol_r, vol_nxt;
  logic [INSP_W-1:0] insp_r, insp_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  logic              last_a_r, last_push_r;
  logic [AGE_W-1:0]  age_r, age_nxt, age_adv;
  logic              changed_r, changed_nxt;
  logic              press, a_fall;

  always_comb begin
    age_adv  = (age_r < AGE_MAX) ? age_r + 1'b1 : age_r;
    press    = last_push_r && !enc_push && (age_adv > holdoff || age_adv == AGE_MAX);
    age_nxt  = press ? '0 : age_adv;
    menu_nxt = menu_r;
    if (press) begin
      menu_nxt = (menu_r < MENU_RATIO) ? menu_r + 1'b1 : MENU_RATE;
    end

    a_fall      = last_a_r && !enc_a;
    changed_nxt = a_fall;
    rate_nxt    = rate_r;
    vol_nxt     = vol_r;
    idx_nxt     = idx_r;
    insp_nxt    = insp_r;
    exp_nxt     = exp_r;
    idx_clamp   = idx_r;
    if (a_fall) begin
      priority if (menu_nxt == MENU_RATE) begin
        if (enc_b && rate_r < RATE_MAX) rate_nxt = rate_r + 1'b1;
        else if (!enc_b && rate_r > RATE_MIN) rate_nxt = rate_r - 1'b1;
      end else if (menu_nxt == MENU_VOL) begin
        if (enc_b && vol_r < VOL_MAX) vol_nxt = vol_r + 1'b1;
        else if (!enc_b && vol_r > VOL_MIN) vol_nxt = vol_r - 1'b1;
      end else if (menu_nxt == MENU_RATIO) begin
        if (enc_b && idx_r < RATIO_LAST) idx_nxt = idx_r + 1'b1;
        else if (!enc_b && idx_r > '0) idx_nxt = idx_r - 1'b1;
        idx_clamp = (idx_nxt > RATIO_LAST) ? RATIO_LAST : idx_nxt;
        insp_nxt  = insp_of(idx_clamp);
        exp_nxt   = exp_of(idx_clamp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r      <= MENU_RATE;
      idx_r       <= '0;
      rate_r      <= RATE_MAX;
      vol_r       <= VOL_MAX;
      insp_r      <= 2'd1;
      exp_r       <= 3'd2;
      last_a_r    <= 1'b1;
      last_push_r <= 1'b1;
      age_r       <= '0;
      changed_r   <= 1'b0;
    end else if (step) begin
      menu_r      <= menu_nxt;
      idx_r       <= idx_nxt;
      rate_r      <= rate_nxt;
      vol_r       <= vol_nxt;
      insp_r      <= insp_nxt;
      exp_r       <= exp_nxt;
      last_a_r    <= enc_a;
      last_push_r <= enc_push;
      age_r       <= age_nxt;
      changed_r   <= changed_nxt;
    end
  end

  assign knob.menu       = menu_r;
  assign knob.rate       = rate_r;
  assign knob.volume     = vol_r;
  assign knob.insp_share = insp_r;
  assign knob.exp_share  = exp_r;
  assign knob.changed    = changed_r;

endmodule

// ===== rtl/core/btk_mul.sv =====
module btk_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [btk_pkg::STEPS_W-1:0] mcand,
  input  logic [btk_pkg::VOL_W-1:0]   mplier,
  output logic                        busy,
  output logic [btk_pkg::PROD_W-1:0]  product
);
  import btk_pkg::*;

  logic                 busy_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    acc_r, a_r;
  logic [VOL_W-1:0]     b_r;

  // LSB-first shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= MUL_CNT_W'(VOL_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= PROD_W'(mcand);
      b_r   <= mplier;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[PROD_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[VOL_W-1:1]};
    end
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule

// ===== rtl/core/btk_div.sv =====
module btk_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [btk_pkg::DIV_DW-1:0] dividend,
  input  logic [btk_pkg::DIV_SW-1:0] divisor,
  output logic                       busy,
  output logic [btk_pkg::DIV_DW-1:0] quotient
);
  import btk_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_SW-1:0]    rem_r, rem_nxt, dsr_r;
  logic [DIV_DW-1:0]    quo_r;
  logic [DIV_SW:0]      trial, diff;
  logic                 fit;

  // restoring, one quotient bit a cycle; dividend shifts out as quotient shifts in
  always_comb begin
    trial   = {rem_r, quo_r[DIV_DW-1]};
    diff    = trial - {1'b0, dsr_r};
    fit     = trial >= {1'b0, dsr_r};
    rem_nxt = fit ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_DW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_DW-2:0], fit};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/breath_timing_knob_control_top.sv =====
// From item accept to result valid: serial multiply, two rounds of bit-serial
//   division, plus sequencing.
// A new item is accepted only when the sequencer is idle, after the previous result is registered.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous): settings and configuration to defaults,
//   no result pending.
module breath_timing_knob_control_top (
  input  logic       clk,
  input  logic       rst_n,
  btk_in_if.sink     in_if,
  btk_out_if.source  out_if,
  btk_cfg_if.sink    cfg_if
);
  import btk_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_TRIM = 3'd4;
  localparam logic [2:0] S_RATE = 3'd5;
  localparam logic [2:0] S_DIV2 = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [STEPS_W-1:0] steps_r;
  logic [TRIM_W-1:0]  insp_trim_r, exp_trim_r;
  logic [AGE_W-1:0]   holdoff_r;

  knob_t              knob;
  logic               in_acc, out_free;

  logic               mul_start, mul_busy;
  logic [PROD_W-1:0]  prod;
  logic               dv0_start, dv0_busy, dv12_start, dv1_busy, dv2_busy;
  logic [DIV_DW-1:0]  dv0_dnd, dv1_dnd, dv2_dnd, dv0_q, dv1_q, dv2_q;
  logic [DIV_SW-1:0]  dv0_dsr, den;
  logic [DIV_DW-1:0]  prod_x10;

  logic [STEPS_W-1:0] stroke_r;
  logic [MS_W-1:0]    insp_ms_r, exp_ms_r, t_insp, t_exp;
  logic [SRATE_W-1:0] srate;

  logic               out_valid_r;
  knob_t              res_knob_r;
  logic [STEPS_W-1:0] res_stroke_r;
  logic [SRATE_W-1:0] res_srate_r;
  logic [MS_W-1:0]    res_insp_r, res_exp_r;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= STEPS_RST;
      insp_trim_r <= INSP_TRIM_RST;
      exp_trim_r  <= EXP_TRIM_RST;
      holdoff_r   <= HOLDOFF_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_STEPS:     steps_r     <= cfg_if.data;
        REG_INSP_TRIM: insp_trim_r <= cfg_if.data[TRIM_W-1:0];
        REG_EXP_TRIM:  exp_trim_r  <= cfg_if.data[TRIM_W-1:0];
        REG_HOLDOFF:   holdoff_r   <= cfg_if.data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  btk_knob u_knob (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_acc),
    .enc_a    (in_if.enc_a),
    .enc_b    (in_if.enc_b),
    .enc_push (in_if.enc_push),
    .holdoff  (holdoff_r),
    .knob     (knob)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MUL;
      S_MUL:  if (!mul_busy) state_nxt = S_DIV1;
      S_DIV1: if (!dv0_busy && !dv1_busy && !dv2_busy) state_nxt = S_TRIM;
      S_TRIM: state_nxt = S_RATE;
      S_RATE: state_nxt = S_DIV2;
      S_DIV2: if (!dv0_busy) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign mul_start  = (state_r == S_LOAD);
  assign dv12_start = (state_r == S_LOAD);
  assign dv0_start  = (state_r == S_MUL && !mul_busy) || (state_r == S_RATE);

  btk_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (steps_r),
    .mplier  (knob.volume),
    .busy    (mul_busy),
    .product (prod)
  );

  assign den      = DIV_SW'(knob.rate * (DEN_W'(knob.insp_share) + DEN_W'(knob.exp_share)));
  assign dv1_dnd  = DIV_DW'(MS_PER_MIN * NUM_W'(knob.insp_share));
  assign dv2_dnd  = DIV_DW'(MS_PER_MIN * NUM_W'(knob.exp_share));
  assign prod_x10 = {prod, 3'b000} + {2'b00, prod, 1'b0};
  assign dv0_dnd  = (state_r == S_RATE) ? prod_x10 : DIV_DW'(prod);
  assign dv0_dsr  = (state_r == S_RATE) ? insp_ms_r : PCT_DIV;

  btk_div u_div0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv0_start),
    .dividend (dv0_dnd),
    .divisor  (dv0_dsr),
    .busy     (dv0_busy),
    .quotient (dv0_q)
  );

  btk_div u_div1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv12_start),
    .dividend (dv1_dnd),
    .divisor  (den),
    .busy     (dv1_busy),
    .quotient (dv1_q)
  );

  btk_div u_div2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv12_start),
    .dividend (dv2_dnd),
    .divisor  (den),
    .busy     (dv2_busy),
    .quotient (dv2_q)
  );

  assign t_insp = dv1_q[MS_W-1:0];
  assign t_exp  = dv2_q[MS_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_TRIM) begin
      stroke_r  <= dv0_q[STEPS_W-1:0];
      insp_ms_r <= (t_insp > MS_W'(insp_trim_r)) ? t_insp - MS_W'(insp_trim_r) : '0;
      exp_ms_r  <= (t_exp > MS_W'(exp_trim_r)) ? t_exp - MS_W'(exp_trim_r) : '0;
    end
  end

  assign srate = (insp_ms_r == '0 || dv0_q[DIV_DW-1:SRATE_W] != '0) ? SRATE_MAX
                                                                     : dv0_q[SRATE_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      res_knob_r   <= knob;
      res_stroke_r <= stroke_r;
      res_srate_r  <= srate;
      res_insp_r   <= insp_ms_r;
      res_exp_r    <= exp_ms_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.menu_pos         = res_knob_r.menu;
  assign out_if.rate_out         = res_knob_r.rate;
  assign out_if.volume_out       = res_knob_r.volume;
  assign out_if.insp_part        = res_knob_r.insp_share;
  assign out_if.exp_part         = res_knob_r.exp_share;
  assign out_if.settings_changed = res_knob_r.changed;
  assign out_if.stroke_steps     = res_stroke_r;
  assign out_if.step_rate        = res_srate_r;
  assign out_if.insp_ms          = res_insp_r;
  assign out_if.exp_ms           = res_exp_r;

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mul_busy && !dv0_busy && !dv1_busy && !dv2_busy)
    else $error("arithmetic unit busy while idle");

  a_zero_insp_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.insp_ms == '0 |-> out_if.step_rate == SRATE_MAX)
    else $error("step rate not saturated for zero inspiration time");

  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.rate_out >= RATE_MIN && out_if.rate_out <= RATE_MAX)
    else $error("breath rate out of range");

  a_menu_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.menu_pos <= MENU_RATIO)
    else $error("menu position out of range");

endmodule
